>>> design/field_line_run_detector_assert.svh
// Assertion macros used by the detector's core module.
`ifndef FIELD_LINE_RUN_DETECTOR_ASSERT_SVH
`define FIELD_LINE_RUN_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FLRD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLRD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/flrd_pkg.sv
package flrd_pkg;

  localparam int SCAN_LEN   = 1024;
  localparam int SCAN_COUNT = 1024;

  localparam int POS_W  = $clog2(SCAN_LEN);
  localparam int RUN_W  = $clog2(SCAN_LEN + 1);
  localparam int SCAN_W = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;

  localparam int LABEL_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = (RUN_W > LABEL_W) ? RUN_W : LABEL_W;

  // mode codes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_FIELD = 2'd1;
  localparam logic [1:0] MODE_LINE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LABEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH   = 2'd3;

  localparam logic [LABEL_W-1:0] LINE_MASK_RST   = 8'h10;
  localparam logic [LABEL_W-1:0] FIELD_LABEL_RST = 8'h08;
  localparam logic [RUN_W-1:0]   MIN_WIDTH_RST   = RUN_W'(1);
  localparam logic [RUN_W-1:0]   MAX_WIDTH_RST   = RUN_W'(10);

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               scan_start;
  } pixel_t;

  typedef struct packed {
    logic [POS_W-1:0]  center;
    logic [RUN_W-1:0]  run_width;
    logic [SCAN_W-1:0] scan_number;
  } result_t;

  typedef struct packed {
    logic [LABEL_W-1:0] line_mask;
    logic [LABEL_W-1:0] field_label;
    logic [RUN_W-1:0]   min_width;
    logic [RUN_W-1:0]   max_width;
  } cfg_t;

endpackage

>>> design/flrd_cfg.sv
module flrd_cfg
  import flrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_mask   <= LINE_MASK_RST;
      cfg.field_label <= FIELD_LABEL_RST;
      cfg.min_width   <= MIN_WIDTH_RST;
      cfg.max_width   <= MAX_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_MASK:   cfg.line_mask   <= cfg_data[LABEL_W-1:0];
        CFG_FIELD_LABEL: cfg.field_label <= cfg_data[LABEL_W-1:0];
        CFG_MIN_WIDTH:   cfg.min_width   <= cfg_data[RUN_W-1:0];
        CFG_MAX_WIDTH:   cfg.max_width   <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/flrd_core.sv
module flrd_core
  import flrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,
  input  pixel_t  item,
  output logic    emit,
  output result_t res
);

  logic [1:0]        mode, mode_s, mode_next;
  logic [RUN_W-1:0]  run_count, run_s, run_next;
  logic [POS_W-1:0]  position, pos_s, pos_next;
  logic [SCAN_W-1:0] scan_count, scan_next;
  logic              begun, begun_next;
  logic              is_field, is_line, in_window;
  logic [RUN_W:0]    half_sum;
  logic [RUN_W-1:0]  half;
  logic [RUN_W-1:0]  pos_ext;

  // scan start acts first, as if a label 0 were seen with no report
  always_comb begin
    mode_s     = mode;
    run_s      = run_count;
    pos_s      = position;
    scan_next  = scan_count;
    begun_next = begun;
    if (item.scan_start) begin
      mode_s     = (cfg.field_label == '0) ? MODE_FIELD : MODE_NONE;
      run_s      = '0;
      pos_s      = '0;
      begun_next = 1'b1;
      if (begun) begin
        scan_next = (scan_count == SCAN_W'(SCAN_COUNT - 1)) ? '0 : scan_count + 1'b1;
      end
    end
  end

  assign is_field  = (item.label == cfg.field_label);
  assign is_line   = ((item.label & cfg.line_mask) != '0);
  assign in_window = (run_s >= cfg.min_width) && (run_s <= cfg.max_width);

  always_comb begin
    mode_next = mode_s;
    run_next  = run_s;
    emit      = 1'b0;
    case (mode_s)
      MODE_NONE: begin
        if (is_field) mode_next = MODE_FIELD;
      end
      MODE_FIELD: begin
        if (is_line) begin
          mode_next = MODE_LINE;
          run_next  = RUN_W'(1);
        end else if (!is_field) begin
          mode_next = MODE_NONE;
        end
      end
      MODE_LINE: begin
        if (is_field) begin
          mode_next = MODE_FIELD;
          emit      = in_window;
        end else if (!is_line) begin
          mode_next = MODE_NONE;
        end else if (run_s < RUN_W'(SCAN_LEN)) begin
          run_next = run_s + 1'b1;
        end
      end
      default: mode_next = MODE_NONE;
    endcase
  end

  assign pos_next = (pos_s < POS_W'(SCAN_LEN - 1)) ? pos_s + 1'b1 : pos_s;

  // center = position - ceil(width/2), clamped at zero
  assign half_sum = {1'b0, run_s} + 1'b1;
  assign half     = half_sum[RUN_W:1];
  assign pos_ext  = RUN_W'(pos_s);

  always_comb begin
    res.run_width   = run_s;
    res.scan_number = scan_next;
    res.center      = (pos_ext >= half) ? POS_W'(pos_ext - half) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NONE;
      run_count  <= '0;
      position   <= '0;
      scan_count <= '0;
      begun      <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      run_count  <= run_next;
      position   <= pos_next;
      scan_count <= scan_next;
      begun      <= begun_next;
    end
  end

`include "field_line_run_detector_assert.svh"

  `FLRD_ASSERT_NOW(a_run_in_range, mode == MODE_LINE, run_count != '0 && run_count <= RUN_W'(SCAN_LEN), "run count out of range in LINE")
  `FLRD_ASSERT_NEXT(a_start_pos, step && item.scan_start, position == POS_W'(1), "position not restarted by scan start")
  `FLRD_ASSERT_NEXT(a_emit_to_field, step && emit, mode == MODE_FIELD, "report without return to FIELD")
  `FLRD_ASSERT_NEXT(a_pos_sat, step && !item.scan_start && position == POS_W'(SCAN_LEN - 1), position == POS_W'(SCAN_LEN - 1), "saturated position moved")

endmodule

>>> design/field_line_run_detector.sv
// A pixel enters the input register; its result leaves from the result register.
// Throughput: one pixel transaction per cycle; the run state machine updates once per pixel.
// The pixel side stalls only while the input register and the result register are both full
// and the result side stalls.
// Reset (rst, synchronous, active high): valids drop, mode NONE, counters zero,
// registers back to line_mask 0x10, field_label 0x08, min_width 1, max_width 10.
module field_line_run_detector
  import flrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // pixel channel
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    in_valid;     // input register holds a pixel
  pixel_t  in_item;
  logic    res_free;     // result register can take a new transaction this cycle
  logic    step;         // pixel in the input register is consumed by the state machine
  logic    emit;
  result_t res;

  flrd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register doubles as the skid point: it frees up when empty or being taken.
  assign res_free    = !result_valid || !result_stall;
  assign step        = in_valid && res_free;
  // Input register refills whenever its pixel moves on or it is empty.
  assign pixel_stall = in_valid && !res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!pixel_stall) begin
      in_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && !pixel_stall) begin
      in_item <= pixel;
    end
  end

  flrd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .item (in_item),
    .emit (emit),
    .res  (res)
  );

  // Most pixels report nothing; only a closed run in the width window loads a transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_free) begin
      result_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result <= res;
    end
  end

endmodule

>>> bench/field_line_run_detector_test.sv
`timescale 1ns / 1ps

// Stream test for the field/line run detector.
module field_line_run_detector_test;
  import flrd_pkg::*;

  localparam int HOLD_CYCLES   = 120;   // long sink hold-off used to back up the pipe
  localparam int DRAIN_CYCLES  = 8;     // pipe depth is two, plus margin
  localparam int STALL_LIMIT   = 4000;  // cycles with no transaction before giving up
  localparam int RANDOM_PIXELS = 940;
  localparam int MAX_PRINTS    = 25;

  // Predicts line hits from accepted pixels and checks them in arrival order.
  class run_scoreboard;
    cfg_t              cfg;
    logic [1:0]        mode;
    logic [RUN_W-1:0]  run_len;
    logic [POS_W-1:0]  pos;
    logic [SCAN_W-1:0] scan_idx;
    bit                started;
    result_t           hits_due[$];
    int                errors;
    int                checked;

    function new();
      cfg.line_mask   = LINE_MASK_RST;
      cfg.field_label = FIELD_LABEL_RST;
      cfg.min_width   = MIN_WIDTH_RST;
      cfg.max_width   = MAX_WIDTH_RST;
      mode     = MODE_NONE;
      run_len  = '0;
      pos      = '0;
      scan_idx = '0;
      started  = 1'b0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LINE_MASK:   cfg.line_mask   = data[LABEL_W-1:0];
        CFG_FIELD_LABEL: cfg.field_label = data[LABEL_W-1:0];
        CFG_MIN_WIDTH:   cfg.min_width   = data[RUN_W-1:0];
        CFG_MAX_WIDTH:   cfg.max_width   = data[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_t p);
      bit      is_field;
      bit      is_line;
      int      half;
      int      c;
      result_t hit;
      if (p.scan_start) begin
        mode    = (cfg.field_label == '0) ? MODE_FIELD : MODE_NONE;
        run_len = '0;
        pos     = '0;
        if (started) begin
          scan_idx = SCAN_W'((int'(scan_idx) + 1) % SCAN_COUNT);
        end else begin
          started  = 1'b1;
          scan_idx = '0;
        end
      end
      is_field = (p.label == cfg.field_label);
      is_line  = ((p.label & cfg.line_mask) != '0);
      case (mode)
        MODE_NONE: begin
          if (is_field) mode = MODE_FIELD;
        end
        MODE_FIELD: begin
          if (is_line) begin
            mode    = MODE_LINE;
            run_len = RUN_W'(1);
          end else if (!is_field) begin
            mode = MODE_NONE;
          end
        end
        MODE_LINE: begin
          if (is_field) begin
            mode = MODE_FIELD;
            if (run_len >= cfg.min_width && run_len <= cfg.max_width) begin
              half = (int'(run_len) + 1) / 2;
              c = (int'(pos) >= half) ? int'(pos) - half : 0;
              hit.center      = POS_W'(c);
              hit.run_width   = run_len;
              hit.scan_number = scan_idx;
              hits_due.push_back(hit);
            end
          end else if (!is_line) begin
            mode = MODE_NONE;
          end else if (run_len < SCAN_LEN) begin
            run_len = run_len + 1'b1;
          end
        end
        default: mode = MODE_NONE;
      endcase
      if (pos < SCAN_LEN - 1) pos = pos + 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_hit(result_t got);
      result_t want;
      if (hits_due.size() == 0) begin
        report($sformatf("unexpected hit center=%0d width=%0d scan=%0d",
                         got.center, got.run_width, got.scan_number));
        return;
      end
      want = hits_due.pop_front();
      checked++;
      if (got.center !== want.center)
        report($sformatf("center %0d, want %0d", got.center, want.center));
      if (got.run_width !== want.run_width)
        report($sformatf("run_width %0d, want %0d", got.run_width, want.run_width));
      if (got.scan_number !== want.scan_number)
        report($sformatf("scan_number %0d, want %0d", got.scan_number, want.scan_number));
    endtask

    function int pending();
      return hits_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  pixel_t                pixel = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  run_scoreboard sb;
  int  pixels_sent = 0;
  int  cfg_writes  = 0;
  int  hold_len    = 0;     // set by the stimulus to request one long sink hold-off
  bit  tx_quiet    = 1'b0;  // no gaps on the pixel side
  bit  rx_quiet    = 1'b0;  // no stalls on the result side

  always #6 clk = ~clk;

  field_line_run_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Per-transaction idle draw; quiet phases give back-to-back traffic.
  function automatic int idle_draw(bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Label with a line-mask bit set and not the field label (falls back to raw random).
  function automatic logic [LABEL_W-1:0] pick_line();
    logic [LABEL_W-1:0] v;
    v = '0;
    for (int i = 0; i < 32; i++) begin
      v = LABEL_W'($urandom_range(0, 255));
      if ((v & sb.cfg.line_mask) != '0 && v != sb.cfg.field_label) return v;
    end
    return v;
  endfunction

  // Label that is neither field nor line colored (falls back to raw random).
  function automatic logic [LABEL_W-1:0] pick_other();
    logic [LABEL_W-1:0] v;
    v = '0;
    for (int i = 0; i < 32; i++) begin
      v = LABEL_W'($urandom_range(0, 255));
      if ((v & sb.cfg.line_mask) == '0 && v != sb.cfg.field_label) return v;
    end
    return v;
  endfunction

  function automatic logic [LABEL_W-1:0] pick_any();
    case ($urandom_range(0, 3))
      0:       return sb.cfg.field_label;
      1:       return pick_line();
      2:       return pick_other();
      default: return LABEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Run width: mostly inside or just outside the window when the window is narrow.
  function automatic int pick_width();
    int lo;
    int hi;
    lo = (sb.cfg.min_width == '0) ? 1 : int'(sb.cfg.min_width);
    hi = int'(sb.cfg.max_width);
    if (lo > hi || hi > 40) return $urandom_range(1, 24);
    case ($urandom_range(0, 9))
      5:       return lo;
      6:       return hi;
      7:       return hi + 1;
      8:       return (lo > 1) ? lo - 1 : lo;
      9:       return $urandom_range(1, 24);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // One pixel transaction: optional gap, then hold valid until the block takes it.
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = idle_draw(tx_quiet);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  task automatic send_label(input logic [LABEL_W-1:0] lab, input logic start);
    pixel_t p;
    p.label      = lab;
    p.scan_start = start;
    send_pixel(p);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_writes++;
  endtask

  // All four registers, back to back; valid drops only after the last one.
  task automatic load_settings(input logic [LABEL_W-1:0] lm, input logic [LABEL_W-1:0] fl,
                               input logic [RUN_W-1:0] mn, input logic [RUN_W-1:0] mx);
    cfg_write(CFG_LINE_MASK, CFG_DATA_W'(lm));
    cfg_write(CFG_FIELD_LABEL, CFG_DATA_W'(fl));
    cfg_write(CFG_MIN_WIDTH, CFG_DATA_W'(mn));
    cfg_write(CFG_MAX_WIDTH, CFG_DATA_W'(mx));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering pixels, wait for every predicted hit, then let the pipe empty.
  // Pixels that yield no hit may still be in flight, hence the extra cycles.
  task automatic settle();
    pixel_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random scans: mostly field / line run / field crossings with random content,
  // the rest noise with the odd stray scan start.
  task automatic random_scans(input int quota);
    int stop_at;
    int segs;
    int w;
    stop_at = pixels_sent + quota;
    while (pixels_sent < stop_at) begin
      send_label(pick_any(), 1'b1);
      segs = $urandom_range(1, 5);
      for (int k = 0; k < segs; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          repeat ($urandom_range(1, 2)) send_label(sb.cfg.field_label, 1'b0);
          w = pick_width();
          repeat (w) send_label(pick_line(), 1'b0);
          send_label(sb.cfg.field_label, 1'b0);
        end else begin
          repeat ($urandom_range(1, 4))
            send_label(LABEL_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
      end
    end
  endtask

  // Result checker: samples pre-edge values, so a transaction is seen at the edge
  // that completes it.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_hit(result);
  end

  // Result sink: random stall per transaction, plus one long hold-off on request.
  initial begin : result_sink
    int k;
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        k = hold_len;
        hold_len = 0;
        result_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end else begin
        k = idle_draw(rx_quiet);
        if (k > 0) begin
          result_stall <= 1'b1;
          repeat (k) @(posedge clk);
        end
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Watchdog: any transaction on any channel resets the count.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int                 remaining;
    int                 chunk;
    logic [LABEL_W-1:0] lm;
    logic [LABEL_W-1:0] fl;
    logic [RUN_W-1:0]   mn;
    logic [RUN_W-1:0]   mx;

    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset settings (mask 0x10, field 0x08, window 1..10) ---
    // pixels before any scan start count as scan 0
    send_label(8'h08, 1'b0);
    send_label(8'h10, 1'b0);
    send_label(8'h08, 1'b0);
    // first scan start keeps scan 0; all-ones label is line colored
    send_label(8'h08, 1'b1);
    send_label(8'hFF, 1'b0);
    send_label(8'h10, 1'b0);
    send_label(8'h08, 1'b0);
    // a run broken by a non-field, non-line pixel reports nothing
    send_label(8'h00, 1'b1);
    send_label(8'h08, 1'b0);
    send_label(8'h10, 1'b0);
    send_label(8'h00, 1'b0);
    settle();

    // field label zero: scan start drops the machine straight into FIELD
    load_settings(8'hFF, 8'h00, '0, RUN_W'(SCAN_LEN));
    send_label(8'h10, 1'b1);
    send_label(8'h00, 1'b0);
    send_label(8'hFF, 1'b0);
    send_label(8'h80, 1'b0);
    send_label(8'h00, 1'b0);
    settle();

    // field label that is also line colored: FIELD sees it as line, LINE as field
    load_settings(8'h10, 8'h18, RUN_W'(2), RUN_W'(2));
    send_label(8'h18, 1'b1);
    send_label(8'h18, 1'b0);
    send_label(8'h18, 1'b0);
    send_label(8'h10, 1'b0);
    send_label(8'h10, 1'b0);
    send_label(8'h18, 1'b0);
    settle();

    // empty mask and empty window: nothing can be reported
    load_settings(8'h00, 8'hFF, RUN_W'(5), RUN_W'(4));
    send_label(8'hFF, 1'b1);
    send_label(8'h7F, 1'b0);
    send_label(8'hFF, 1'b0);
    settle();

    // --- back-pressure: sink holds off while pixels keep coming, one hit per pair ---
    load_settings(LINE_MASK_RST, FIELD_LABEL_RST, MIN_WIDTH_RST, MAX_WIDTH_RST);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    hold_len = HOLD_CYCLES;
    repeat (40) begin
      send_label(8'h08, 1'b0);
      send_label(8'h10, 1'b0);
    end
    send_label(8'h08, 1'b0);
    settle();

    // --- random phases, each with its own register settings and idle pattern ---
    remaining = RANDOM_PIXELS;
    while (remaining > 0) begin
      chunk = $urandom_range(80, 160);
      if (chunk > remaining) chunk = remaining;
      settle();
      lm = LABEL_W'($urandom_range(1, 255));
      case ($urandom_range(0, 5))
        0: begin
          lm = LINE_MASK_RST;
          fl = FIELD_LABEL_RST;
          mn = MIN_WIDTH_RST;
          mx = MAX_WIDTH_RST;
        end
        1: begin
          fl = LABEL_W'($urandom_range(0, 255)) & ~lm;
          mn = RUN_W'($urandom_range(0, 6));
          mx = mn + RUN_W'($urandom_range(0, 15));
        end
        2: begin
          // field label shares a bit with the line mask
          fl = LABEL_W'($urandom_range(0, 255)) | (lm & (~lm + 8'd1));
          mn = RUN_W'($urandom_range(0, 6));
          mx = mn + RUN_W'($urandom_range(0, 15));
        end
        3: begin
          fl = '0;
          mn = RUN_W'($urandom_range(1, 4));
          mx = mn + RUN_W'($urandom_range(0, 20));
        end
        4: begin
          // empty window, sometimes max pinned at zero
          fl = LABEL_W'($urandom_range(0, 255)) & ~lm;
          mn = RUN_W'($urandom_range(2, 12));
          mx = ($urandom_range(0, 3) == 0) ? '0 : mn - RUN_W'($urandom_range(1, 2));
        end
        default: begin
          fl = LABEL_W'($urandom_range(0, 255)) & ~lm;
          mn = '0;
          mx = RUN_W'(SCAN_LEN);
        end
      endcase
      load_settings(lm, fl, mn, mx);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      random_scans(chunk);
      remaining = remaining - chunk;
    end

    settle();
    $display("Covered %0d pixel transactions, %0d line hits checked, %0d register writes;",
             pixels_sent, sb.checked, cfg_writes);
    $display("zero field label, shared field/line label, empty windows and sink back-pressure");
    $display("included, %0d mismatches", sb.errors);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/flrd_pkg.sv
design/flrd_cfg.sv
design/flrd_core.sv
design/field_line_run_detector.sv
bench/field_line_run_detector_test.sv
